/* src/apsd_pkg.sv */
// Shared types and constants of the ADPCM / PCM sample decoder.
`timescale 1ns / 1ps
`default_nettype none
package apsd_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_DECODE_FORMAT = 3'd0;
  localparam logic [2:0] REG_OUTPUT_MODE   = 3'd1;
  localparam logic [2:0] REG_PCM_GAIN      = 3'd2;
  localparam logic [2:0] REG_COEF_WORD_A   = 3'd3;
  localparam logic [2:0] REG_COEF_WORD_B   = 3'd4;
  localparam logic [2:0] REG_COEF_WORD_C   = 3'd5;
  localparam logic [2:0] REG_COEF_WORD_D   = 3'd6;

  // Decode formats
  localparam logic [1:0] FMT_ADPCM = 2'd0;
  localparam logic [1:0] FMT_PCM8  = 2'd1;
  localparam logic [1:0] FMT_PCM16 = 2'd2;
  localparam logic [1:0] FMT_ZERO  = 2'd3;

  // Output modes
  localparam logic [1:0] OMODE_CLAMP = 2'd0;
  localparam logic [1:0] OMODE_LOW   = 2'd1;
  localparam logic [1:0] OMODE_HIGH  = 2'd2;
  localparam logic [1:0] OMODE_BAD   = 2'd3;

  localparam int unsigned SCALE_MAX   = 12;
  localparam int unsigned FRAC_SHIFT  = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ADPCM = 2'd1,
    KIND_PCM   = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_t;

  // One classified transaction, front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;    // pcm sample or load_newer
    logic signed [15:0] older;     // load_older
    logic signed [15:0] coef_new;
    logic signed [15:0] coef_old;
    logic signed [26:0] nib_term;  // nibble * 2048 * 2^scale
  } item_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

endpackage
`default_nettype wire

/* src/apsd_front.sv */
// Front end: input handshake and classification of each transaction.
`timescale 1ns / 1ps
`default_nettype none
module apsd_front (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [15:0]        in_raw_sample,
  input  wire logic [2:0]         in_predictor_index,
  input  wire logic [3:0]         in_scale_shift,
  input  wire logic signed [15:0] in_load_newer,
  input  wire logic signed [15:0] in_load_older,
  input  wire logic [1:0]         decode_format,
  input  wire logic [255:0]       coef_flat,
  input  wire logic               q_full,
  output logic                    q_push,
  output apsd_pkg::item_t         q_item
);

  logic [3:0]         scale_c;
  logic signed [26:0] nib_ext;
  logic [4:0]         shamt;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    scale_c = (in_scale_shift > 4'(apsd_pkg::SCALE_MAX)) ?
              4'(apsd_pkg::SCALE_MAX) : in_scale_shift;
    nib_ext = 27'($signed(in_raw_sample[3:0]));
    shamt   = 5'(apsd_pkg::FRAC_SHIFT) + {1'b0, scale_c};

    q_item.coef_new = coef_flat[{in_predictor_index, 5'd0} +: 16];
    q_item.coef_old = coef_flat[{in_predictor_index, 1'b1, 4'd0} +: 16];
    q_item.nib_term = nib_ext <<< shamt;
    q_item.older    = in_load_older;
    q_item.sample   = in_load_newer;

    if (in_cmd) begin
      q_item.kind = apsd_pkg::KIND_LOAD;
    end else begin
      case (decode_format)
        apsd_pkg::FMT_ADPCM: q_item.kind = apsd_pkg::KIND_ADPCM;
        apsd_pkg::FMT_PCM8: begin
          q_item.kind   = apsd_pkg::KIND_PCM;
          q_item.sample = {in_raw_sample[7:0], 8'd0};
        end
        apsd_pkg::FMT_PCM16: begin
          q_item.kind   = apsd_pkg::KIND_PCM;
          q_item.sample = in_raw_sample;
        end
        default: q_item.kind = apsd_pkg::KIND_ZERO;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/apsd_queue.sv */
// Short queue of classified transactions between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module apsd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire apsd_pkg::item_t push_item,
  output logic                 full,
  output apsd_pkg::qctl_t      ctl_valid,
  input  wire apsd_pkg::qctl_t ctl_pop,
  output apsd_pkg::item_t      head
);

  localparam int unsigned D  = apsd_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  apsd_pkg::item_t entry_r [D];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign full            = (count_r == CW'(D));
  assign ctl_valid.valid = (count_r != '0);
  assign ctl_valid.pop   = 1'b0;
  assign do_pop          = ctl_pop.pop & ctl_valid.valid;
  assign head            = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/apsd_back.sv */
// Back end: history, multiply-accumulate, output formatting and output register.
`timescale 1ns / 1ps
`default_nettype none
module apsd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire apsd_pkg::qctl_t    q_ctl,
  output apsd_pkg::qctl_t         q_pop,
  input  wire apsd_pkg::item_t    item,
  input  wire logic [1:0]         output_mode,
  input  wire logic [15:0]        pcm_gain,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_decoded_sample,
  output logic                    out_mode_error,
  output logic signed [15:0]      out_newer_now,
  output logic signed [15:0]      out_older_now
);

  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        dec_r;
  logic               err_r;
  logic signed [15:0] hist_newer_r, hist_newer_nxt;
  logic signed [15:0] hist_older_r, hist_older_nxt;

  logic               take;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod_a;
  logic signed [31:0] prod_b;
  logic signed [34:0] sum;
  logic signed [34:0] sum_sh;
  logic [15:0]        dec_val;
  logic               err_val;

  assign take      = q_ctl.valid & (~out_valid_r | ~out_stall);
  assign q_pop.pop   = take;
  assign q_pop.valid = 1'b0;

  always_comb begin
    if (item.kind == apsd_pkg::KIND_ADPCM) begin
      mul_a = {hist_newer_r[15], hist_newer_r};
      mul_b = {item.coef_new[15], item.coef_new};
    end else begin
      mul_a = {item.sample[15], item.sample};
      mul_b = $signed({1'b0, pcm_gain});
    end
    prod_a = mul_a * mul_b;
    prod_b = hist_older_r * item.coef_old;

    case (item.kind)
      apsd_pkg::KIND_ADPCM: sum = 35'(prod_a) + 35'(prod_b) + 35'(item.nib_term);
      apsd_pkg::KIND_PCM:   sum = 35'(prod_a);
      default:              sum = '0;
    endcase
    sum_sh = sum >>> apsd_pkg::FRAC_SHIFT;

    err_val = 1'b0;
    case (output_mode)
      apsd_pkg::OMODE_CLAMP: begin
        if (sum_sh > 35'sd32767) begin
          dec_val = 16'h7FFF;
        end else if (sum_sh < -35'sd32768) begin
          dec_val = 16'h8000;
        end else begin
          dec_val = sum_sh[15:0];
        end
      end
      apsd_pkg::OMODE_LOW:  dec_val = sum[15:0];
      apsd_pkg::OMODE_HIGH: dec_val = sum[31:16];
      default: begin
        dec_val = 16'd0;
        err_val = 1'b1;
      end
    endcase

    hist_newer_nxt = hist_newer_r;
    hist_older_nxt = hist_older_r;
    case (item.kind)
      apsd_pkg::KIND_LOAD: begin
        hist_newer_nxt = item.sample;
        hist_older_nxt = item.older;
        dec_val        = 16'd0;
        err_val        = 1'b0;
      end
      apsd_pkg::KIND_ADPCM: begin
        hist_older_nxt = hist_newer_r;
        hist_newer_nxt = sum_sh[15:0];
      end
      default: begin
      end
    endcase

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hist_newer_r <= '0;
      hist_older_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        hist_newer_r <= hist_newer_nxt;
        hist_older_r <= hist_older_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_r         <= dec_val;
      err_r         <= err_val;
      out_newer_now <= hist_newer_nxt;
      out_older_now <= hist_older_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_decoded_sample = dec_r;
  assign out_mode_error     = err_r;

endmodule
`default_nettype wire

/* src/adpcm_pcm_sample_decoder_core.sv */
// Top level of the ADPCM / PCM sample decoder: configuration registers and the datapath.
//
// Usage:
//  - Input channel (in_*): one transaction per sample; cmd 0 decodes raw_sample per the
//    configured format, cmd 1 loads the two history samples. Accepted at a clock edge
//    with in_valid high and in_stall low.
//  - Result channel (out_*): exactly one result per input transaction, in order,
//    taken at an edge with out_valid high and out_stall low.
//  - Configuration (cfg_*): write cfg_wdata to register cfg_index when cfg_wr_en is
//    high; only while no transaction is in flight. Unlisted indexes are dropped.
//  - An accepted input is written to the queue, taken from its head by the back end
//    and held in the output register. Throughput: one sample per cycle while
//    out_stall is low, set by the history multiply-accumulate loop in the back end.
//  - The front end classifies the transaction and picks the coefficient pair; a
//    two-entry queue decouples it from the back end, which owns the history.
//  - When out_stall is high the output register holds its result, the queue fills,
//    and in_stall rises once both queue entries are occupied.
//  - Synchronous active-low reset clears the history, the configuration registers and all valids.
`timescale 1ns / 1ps
`default_nettype none
module adpcm_pcm_sample_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [15:0]        in_raw_sample,
  input  wire logic [2:0]         in_predictor_index,
  input  wire logic [3:0]         in_scale_shift,
  input  wire logic signed [15:0] in_load_newer,
  input  wire logic signed [15:0] in_load_older,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_decoded_sample,
  output logic                    out_mode_error,
  output logic signed [15:0]      out_newer_now,
  output logic signed [15:0]      out_older_now
);

  // Configuration registers
  logic [1:0]  decode_format_r;
  logic [1:0]  output_mode_r;
  logic [15:0] pcm_gain_r;
  logic [63:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_format_r <= '0;
      output_mode_r   <= '0;
      pcm_gain_r      <= '0;
      coef_a_r        <= '0;
      coef_b_r        <= '0;
      coef_c_r        <= '0;
      coef_d_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apsd_pkg::REG_DECODE_FORMAT: decode_format_r <= cfg_wdata[1:0];
        apsd_pkg::REG_OUTPUT_MODE:   output_mode_r   <= cfg_wdata[1:0];
        apsd_pkg::REG_PCM_GAIN:      pcm_gain_r      <= cfg_wdata[15:0];
        apsd_pkg::REG_COEF_WORD_A:   coef_a_r        <= cfg_wdata;
        apsd_pkg::REG_COEF_WORD_B:   coef_b_r        <= cfg_wdata;
        apsd_pkg::REG_COEF_WORD_C:   coef_c_r        <= cfg_wdata;
        apsd_pkg::REG_COEF_WORD_D:   coef_d_r        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sixteen coefficients, coefficient 0 in the lowest bits
  logic [255:0] coef_flat;
  assign coef_flat = {coef_d_r, coef_c_r, coef_b_r, coef_a_r};

  logic            q_full;
  logic            q_push;
  apsd_pkg::item_t q_item;
  apsd_pkg::item_t q_head;
  apsd_pkg::qctl_t q_status;
  apsd_pkg::qctl_t q_pop;

  apsd_front u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_raw_sample      (in_raw_sample),
    .in_predictor_index (in_predictor_index),
    .in_scale_shift     (in_scale_shift),
    .in_load_newer      (in_load_newer),
    .in_load_older      (in_load_older),
    .decode_format      (decode_format_r),
    .coef_flat          (coef_flat),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_item)
  );

  apsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .ctl_valid (q_status),
    .ctl_pop   (q_pop),
    .head      (q_head)
  );

  apsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_ctl              (q_status),
    .q_pop              (q_pop),
    .item               (q_head),
    .output_mode        (output_mode_r),
    .pcm_gain           (pcm_gain_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_sample (out_decoded_sample),
    .out_mode_error     (out_mode_error),
    .out_newer_now      (out_newer_now),
    .out_older_now      (out_older_now)
  );

endmodule
`default_nettype wire

/* verif/tb_adpcm_pcm_sample_decoder_core.sv */
// Self-checking testbench for the ADPCM / PCM sample decoder core.
`timescale 1ns / 1ps
module tb_adpcm_pcm_sample_decoder_core;
  import apsd_pkg::*;

  // Command codes of the input transaction
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam longint NIBBLE_STEP = 2048;
  localparam longint SAMPLE_MAX  = 32767;
  localparam longint SAMPLE_MIN  = -32768;
  localparam int unsigned HIGH_SHIFT = 16;

  localparam int DUT_LATENCY     = 2;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_ITEMS      = 40;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DRAIN_LIMIT     = 100000;
  localparam longint RUN_LIMIT_NS = 2000000;

  // One result transaction as the decoder should produce it
  typedef struct {
    logic [15:0]        sample;
    logic               mode_error;
    logic signed [15:0] newer;
    logic signed [15:0] older;
  } decoded_t;

  // Tracks configuration and history, predicts each result and checks it in order.
  class sample_scoreboard;
    logic [1:0]         fmt_reg;
    logic [1:0]         omode_reg;
    logic [15:0]        gain_reg;
    logic [63:0]        coef_bank [4];
    logic signed [15:0] hist_new;
    logic signed [15:0] hist_old;
    decoded_t           awaited_samples [$];
    int unsigned        mismatches;

    function new();
      fmt_reg    = FMT_ADPCM;
      omode_reg  = OMODE_CLAMP;
      gain_reg   = '0;
      foreach (coef_bank[i]) coef_bank[i] = '0;
      hist_new   = '0;
      hist_old   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_DECODE_FORMAT: fmt_reg = data[1:0];
        REG_OUTPUT_MODE:   omode_reg = data[1:0];
        REG_PCM_GAIN:      gain_reg = data[15:0];
        REG_COEF_WORD_A, REG_COEF_WORD_B, REG_COEF_WORD_C, REG_COEF_WORD_D:
          coef_bank[idx - REG_COEF_WORD_A] = data;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] pick_coef(int unsigned k);
      return $signed(coef_bank[k / 4][(k % 4) * 16 +: 16]);
    endfunction

    function void note_sample(logic cmd, logic [15:0] raw, logic [2:0] pred,
                              logic [3:0] scale, logic signed [15:0] load_new,
                              logic signed [15:0] load_old);
      decoded_t          want;
      longint            acc;
      longint            scaled;
      int unsigned       sc;
      logic signed [3:0] nib;
      want.sample     = '0;
      want.mode_error = 1'b0;
      if (cmd == CMD_LOAD) begin
        hist_new = load_new;
        hist_old = load_old;
      end else begin
        acc = 0;
        case (fmt_reg)
          FMT_ADPCM: begin
            sc  = (scale > SCALE_MAX) ? SCALE_MAX : scale;
            nib = raw[3:0];
            acc = longint'(hist_new) * longint'(pick_coef(2 * pred))
                + longint'(hist_old) * longint'(pick_coef(2 * pred + 1))
                + ((longint'(nib) * NIBBLE_STEP) <<< sc);
            hist_old = hist_new;
            scaled   = acc >>> FRAC_SHIFT;
            hist_new = scaled[15:0];
          end
          FMT_PCM8:  acc = longint'($signed({raw[7:0], 8'h00})) * longint'(gain_reg);
          FMT_PCM16: acc = longint'($signed(raw)) * longint'(gain_reg);
          default:   acc = 0;
        endcase
        case (omode_reg)
          OMODE_CLAMP: begin
            scaled = acc >>> FRAC_SHIFT;
            if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
            else if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
            want.sample = scaled[15:0];
          end
          OMODE_LOW: want.sample = acc[15:0];
          OMODE_HIGH: begin
            scaled      = acc >>> HIGH_SHIFT;
            want.sample = scaled[15:0];
          end
          default: want.mode_error = 1'b1;
        endcase
      end
      want.newer = hist_new;
      want.older = hist_old;
      awaited_samples.push_back(want);
    endfunction

    function void check_sample(logic [15:0] sample, logic err,
                               logic signed [15:0] newer, logic signed [15:0] older);
      decoded_t want;
      if (awaited_samples.size() == 0) begin
        $error("result transaction %h with nothing pending", sample);
        mismatches++;
        return;
      end
      want = awaited_samples.pop_front();
      if (sample !== want.sample) begin
        $error("decoded_sample: expected %h, got %h", want.sample, sample);
        mismatches++;
      end
      if (err !== want.mode_error) begin
        $error("mode_error: expected %b, got %b", want.mode_error, err);
        mismatches++;
      end
      if (newer !== want.newer) begin
        $error("newer_now: expected %h, got %h", want.newer, newer);
        mismatches++;
      end
      if (older !== want.older) begin
        $error("older_now: expected %h, got %h", want.older, older);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [15:0]        in_raw_sample;
  logic [2:0]         in_predictor_index;
  logic [3:0]         in_scale_shift;
  logic signed [15:0] in_load_newer;
  logic signed [15:0] in_load_older;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_decoded_sample;
  logic               out_mode_error;
  logic signed [15:0] out_newer_now;
  logic signed [15:0] out_older_now;

  // Idle rates in percent per cycle; the receiver's is sampled by its own process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  logic        hold_active    = 1'b0;

  sample_scoreboard sb = new();

  adpcm_pcm_sample_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_raw_sample      (in_raw_sample),
    .in_predictor_index (in_predictor_index),
    .in_scale_shift     (in_scale_shift),
    .in_load_newer      (in_load_newer),
    .in_load_older      (in_load_older),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_sample (out_decoded_sample),
    .out_mode_error     (out_mode_error),
    .out_newer_now      (out_newer_now),
    .out_older_now      (out_older_now)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver back-pressure: random per cycle, forced high during the long hold-off.
  // Independent of out_valid, so it never shapes what the block offers.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_active ||
                   (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  // The two-entry queue plus the output register fill, and in_stall must rise.
  initial begin : receiver_hold
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Monitor: both channels sampled at the edge, before the edge's updates land.
  // Inputs are noted first so a same-edge result would still find its prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_cmd, in_raw_sample, in_predictor_index, in_scale_shift,
                       in_load_newer, in_load_older);
      end
      if (out_valid && !out_stall) begin
        sb.check_sample(out_decoded_sample, out_mode_error, out_newer_now, out_older_now);
      end
    end
  end

  // Offer one transaction, with a random gap first, and wait for it to be taken.
  // Valid stays high across back-to-back transactions; the payload only changes
  // once the previous one was accepted.
  task automatic send_sample(input logic cmd, input logic [15:0] raw,
                             input logic [2:0] pred, input logic [3:0] scale,
                             input logic signed [15:0] load_new,
                             input logic signed [15:0] load_old);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_raw_sample      <= raw;
    in_predictor_index <= pred;
    in_scale_shift     <= scale;
    in_load_newer      <= load_new;
    in_load_older      <= load_old;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [15:0] pick_history();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly decodes with random content; the occasional load reseeds the history
  // so the ADPCM recursion does not settle into a fixed point.
  task automatic send_random_item();
    logic cmd;
    cmd = ($urandom_range(99) < 8) ? CMD_LOAD : CMD_DECODE;
    send_sample(cmd, 16'($urandom), 3'($urandom_range(7)), 4'($urandom_range(15)),
                pick_history(), pick_history());
  endtask

  // Drop valid and wait until every predicted result has been taken.
  // One edge first, so the monitor has noted the last accepted transaction.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_samples.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  // Write all seven registers back to back; only called with the block idle.
  task automatic configure(input logic [1:0] fmt, input logic [1:0] mode,
                           input logic [15:0] gain, input logic [63:0] word_a,
                           input logic [63:0] word_b, input logic [63:0] word_c,
                           input logic [63:0] word_d);
    logic [63:0] vals [7];
    vals[REG_DECODE_FORMAT] = {62'd0, fmt};
    vals[REG_OUTPUT_MODE]   = {62'd0, mode};
    vals[REG_PCM_GAIN]      = {48'd0, gain};
    vals[REG_COEF_WORD_A]   = word_a;
    vals[REG_COEF_WORD_B]   = word_b;
    vals[REG_COEF_WORD_C]   = word_c;
    vals[REG_COEF_WORD_D]   = word_d;
    for (int i = REG_DECODE_FORMAT; i <= REG_COEF_WORD_D; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] pick_coef_word();
    case ($urandom_range(3))
      0:       return 64'h8000_8000_8000_8000;
      1:       return 64'h7FFF_7FFF_7FFF_7FFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [1:0] fmt;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_DECODE_FORMAT;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_cmd             <= CMD_DECODE;
    in_raw_sample      <= '0;
    in_predictor_index <= '0;
    in_scale_shift     <= '0;
    in_load_newer      <= '0;
    in_load_older      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ADPCM with extreme coefficients. Full-scale history, both nibble
    // extremes, zero nibble and scale above the clamp.
    configure(FMT_ADPCM, OMODE_CLAMP, 16'hFFFF, 64'h8000_8000_7FFF_8000,
              64'h7FFF_7FFF_0001_FFFF, 64'h0000_0000_0800_F800, 64'h8000_7FFF_0000_0000);
    send_sample(CMD_LOAD,   16'h0000, 3'd0, 4'd0,  16'sh7FFF, 16'sh8000);
    send_sample(CMD_DECODE, 16'h0007, 3'd0, 4'd15, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'hFFF8, 3'd7, 4'd12, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'h0000, 3'd1, 4'd0,  16'sh0000, 16'sh0000);
    send_sample(CMD_LOAD,   16'h0000, 3'd0, 4'd0,  16'sh8000, 16'sh8000);
    send_sample(CMD_DECODE, 16'hFFFF, 3'd0, 4'd13, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'hABC3, 3'd5, 4'd14, 16'sh0000, 16'sh0000);
    settle();
    // Unsupported output mode: flag set, sample zero, history still shifts
    configure(FMT_ADPCM, OMODE_BAD, 16'hFFFF, 64'h7FFF_7FFF_7FFF_7FFF,
              64'h8000_8000_8000_8000, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(CMD_DECODE, 16'h0005, 3'd4, 4'd3, 16'sh0000, 16'sh0000);
    send_sample(CMD_LOAD,   16'h0000, 3'd0, 4'd0, 16'sh0001, 16'shFFFF);
    send_sample(CMD_DECODE, 16'h0009, 3'd2, 4'd15, 16'sh0000, 16'sh0000);
    settle();
    // PCM8: only the low byte counts, full gain, low 16 bits out
    configure(FMT_PCM8, OMODE_LOW, 16'hFFFF, '0, '0, '0, '0);
    send_sample(CMD_DECODE, 16'h0080, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'hFF7F, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'h12FF, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    settle();
    // PCM16 at both ends of the range, high half out
    configure(FMT_PCM16, OMODE_HIGH, 16'hFFFF, '0, '0, '0, '0);
    send_sample(CMD_DECODE, 16'h8000, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'h7FFF, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'hFFFF, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    settle();
    // PCM16 saturating in both directions
    configure(FMT_PCM16, OMODE_CLAMP, 16'hFFFF, '0, '0, '0, '0);
    send_sample(CMD_DECODE, 16'h8000, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    send_sample(CMD_DECODE, 16'h7FFF, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    settle();
    // Zero format: sum is zero and history is kept
    configure(FMT_ZERO, OMODE_CLAMP, 16'h0000, '0, '0, '0, '0);
    send_sample(CMD_DECODE, 16'h1234, 3'd6, 4'd9, 16'sh0000, 16'sh0000);
    send_sample(CMD_LOAD,   16'h0000, 3'd0, 4'd0, 16'sh0000, 16'sh0000);
    settle();

    // Random phases: a fresh configuration each, cycling through the idle patterns.
    // Even phases decode ADPCM, where the history feedback matters most.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fmt = (p % 2 == 0) ? FMT_ADPCM : 2'($urandom_range(3));
      configure(fmt, 2'($urandom_range(3)), pick_gain(), pick_coef_word(),
                pick_coef_word(), pick_coef_word(), pick_coef_word());
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
        default: begin send_idle_pct = 16; recv_stall_pct <= 16; end
      endcase
      if (p == 0) begin
        // Receiver holds off while the sender streams without gaps
        hold_request = 1'b1;
        repeat (HOLD_ITEMS) send_random_item();
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
      settle();
    end

    if (sb.awaited_samples.size() != 0) begin
      $error("%0d result transactions never arrived", sb.awaited_samples.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("PASS adpcm_pcm_sample_decoder_core");
    end else begin
      $display("FAIL adpcm_pcm_sample_decoder_core");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL adpcm_pcm_sample_decoder_core");
    $finish;
  end

endmodule
